// ----- src/trp_pkg.sv -----
// trp_pkg: shared types and constants for the TGA RLE pixel decoder.
// No dependencies; compile first.
package trp_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd3;

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  count;
		logic        clip;
		logic [7:0]  rem_lo;
	} pix_entry_t;

endpackage

// ----- src/trp_if.sv -----
// trp_in_if / trp_out_if: valid/ready channels of the TGA RLE pixel decoder.
// No dependencies.
interface trp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       image_start;

	modport source(output valid, output data_byte, output image_start, input ready);
	modport sink(input valid, input data_byte, input image_start, output ready);
endinterface

interface trp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_value;
	logic [7:0]  repeat_count;
	logic        last_pixel;

	modport source(output valid, output pixel_value, output repeat_count, output last_pixel,
		input ready);
	modport sink(input valid, input pixel_value, input repeat_count, input last_pixel,
		output ready);
endinterface

// ----- src/tga_rle_pixel_decoder.sv -----
// Channel   Dir  Payload                                   Transaction when
// in_ch     in   data_byte[7:0], image_start               valid && ready
// out_ch    out  pixel_value[31:0], repeat_count[7:0],     valid && ready
//                last_pixel
// cfg       in   cfg_index[1:0], cfg_wdata[15:0]            cfg_we
//
// One byte per cycle unless the pixel queue is full; a pixel result passes through the queue, then the output register.
// The front parses packets and gathers pixel bytes as each byte is accepted.
// The QDEPTH-entry pixel queue decouples input from output; in_ch.ready drops
// only when it is full. arst_n clears the control state, not the queue or output data; config takes its reset values.
// Depends on trp_pkg, trp_if, trp_front, trp_queue, trp_back.
module tga_rle_pixel_decoder #(
	parameter int QDEPTH = trp_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	trp_in_if.sink                         in_ch,
	trp_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [trp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	trp_pkg::pix_entry_t push_entry, pop_entry;
	logic                push, pop, full, not_empty;

	trp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (full),
		.q_push    (push),
		.q_entry   (push_entry)
	);

	trp_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (push_entry),
		.pop       (pop),
		.rd_entry  (pop_entry),
		.full      (full),
		.not_empty (not_empty)
	);

	trp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_entry (pop_entry),
		.q_pop   (pop),
		.out_ch  (out_ch)
	);

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.repeat_count != 8'd0 && out_ch.repeat_count <= 8'd128)
		else $error("repeat count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("pixel queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pixel queue underflow");
`endif

endmodule

// ----- src/trp_front.sv -----
// trp_front: configuration registers, packet parser, pixel gather and pixel counter.
// Depends on trp_pkg and trp_in_if.
module trp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	trp_in_if.sink                            in_ch,
	input  logic                              cfg_we,
	input  logic [trp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [trp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              q_full,
	output logic                              q_push,
	output trp_pkg::pix_entry_t               q_entry
);

	localparam logic [1:0] PH_HDR    = 2'd0;
	localparam logic [1:0] PH_RAW    = 2'd1;
	localparam logic [1:0] PH_REPEAT = 2'd2;

	logic        rle_q;
	logic [2:0]  bpp_q;
	logic [15:0] width_q, height_q;
	logic [31:0] area_q;
	logic [15:0] mul_a, mul_b;
	logic [31:0] area_d;

	logic [1:0]  phase_q, phase_e, phase_n;
	logic [7:0]  left_q, left_e, left_n;
	logic [1:0]  bpos_q, bpos_e, bpos_n;
	logic [31:0] gather_q, gather_e, gather_n, gather_or;
	logic [31:0] rem_q, rem_e, rem_n;
	logic [2:0]  bpp_eff;
	logic        accept, fire, clip;
	logic [7:0]  count;

	function automatic logic [2:0] eff_bpp(input logic [2:0] b);
		logic [2:0] r;
		r = b;
		if (b == 3'd0) r = 3'd1;
		else if (b > 3'd4) r = 3'd4;
		return r;
	endfunction

	// width*height is formed at the write, so it is ready for the next byte
	always_comb begin
		mul_a  = (cfg_index == trp_pkg::REG_WIDTH) ? cfg_wdata : width_q;
		mul_b  = (cfg_index == trp_pkg::REG_HEIGHT) ? cfg_wdata : height_q;
		area_d = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_q    <= 1'b1;
			bpp_q    <= 3'd3;
			width_q  <= 16'd1;
			height_q <= 16'd1;
			area_q   <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				trp_pkg::REG_RLE_ENABLE: rle_q <= cfg_wdata[0];
				trp_pkg::REG_BPP:        bpp_q <= cfg_wdata[2:0];
				trp_pkg::REG_WIDTH: begin
					width_q <= cfg_wdata;
					area_q  <= area_d;
				end
				trp_pkg::REG_HEIGHT: begin
					height_q <= cfg_wdata;
					area_q   <= area_d;
				end
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		bpp_eff  = eff_bpp(bpp_q);
		phase_e  = in_ch.image_start ? PH_HDR : phase_q;
		left_e   = in_ch.image_start ? 8'd0 : left_q;
		bpos_e   = in_ch.image_start ? 2'd0 : bpos_q;
		gather_e = in_ch.image_start ? 32'd0 : gather_q;
		rem_e    = in_ch.image_start ? area_q : rem_q;

		gather_or = gather_e | ({24'd0, in_ch.data_byte} << {bpos_e, 3'b000});

		phase_n  = phase_e;
		left_n   = left_e;
		bpos_n   = bpos_e;
		gather_n = gather_e;
		rem_n    = rem_e;
		fire     = 1'b0;
		count    = 8'd1;
		clip     = 1'b0;

		if (rem_e != 32'd0) begin
			if (rle_q && phase_e == PH_HDR) begin
				phase_n  = in_ch.data_byte[7] ? PH_REPEAT : PH_RAW;
				left_n   = in_ch.data_byte[7] ? {1'b0, in_ch.data_byte[6:0]} : in_ch.data_byte;
				bpos_n   = 2'd0;
				gather_n = 32'd0;
			end else if (({1'b0, bpos_e} + 3'd1) < bpp_eff) begin
				bpos_n   = bpos_e + 2'd1;
				gather_n = gather_or;
			end else begin
				bpos_n   = 2'd0;
				gather_n = 32'd0;
				fire     = 1'b1;
				if (rle_q) begin
					if (phase_e == PH_REPEAT) begin
						phase_n = PH_HDR;
						count   = left_e + 8'd1;
					end else if (left_e == 8'd0) begin
						phase_n = PH_HDR;
					end else begin
						left_n = left_e - 8'd1;
					end
				end
				clip  = {24'd0, count} >= rem_e;
				rem_n = clip ? 32'd0 : rem_e - {24'd0, count};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			left_q   <= 8'd0;
			bpos_q   <= 2'd0;
			gather_q <= 32'd0;
			rem_q    <= 32'd0;
		end else if (accept) begin
			phase_q  <= phase_n;
			left_q   <= left_n;
			bpos_q   <= bpos_n;
			gather_q <= gather_n;
			rem_q    <= rem_n;
		end
	end

	assign q_push         = accept && fire;
	assign q_entry.value  = gather_or;
	assign q_entry.count  = count;
	assign q_entry.clip   = clip;
	assign q_entry.rem_lo = rem_e[7:0];

`ifndef SYNTH
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_entry.clip |=> rem_q == 32'd0)
		else $error("pixel counter not empty after last pixel");
	a_push_owed: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> rem_e != 32'd0)
		else $error("pixel pushed with none owed");
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_REPEAT |-> left_q <= 8'd127)
		else $error("repeat run longer than 128");
`endif

endmodule

// ----- src/trp_queue.sv -----
// trp_queue: short FIFO of decoded pixels between front and back.
// Depends on trp_pkg.
module trp_queue #(
	parameter int DEPTH = trp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  trp_pkg::pix_entry_t wr_entry,
	input  logic                pop,
	output trp_pkg::pix_entry_t rd_entry,
	output logic                full,
	output logic                not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	trp_pkg::pix_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop) rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- src/trp_back.sv -----
// trp_back: takes queued pixels, clips the run at the image end, holds the output register.
// Depends on trp_pkg and trp_out_if.
module trp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  trp_pkg::pix_entry_t q_entry,
	output logic                q_pop,
	trp_out_if.source           out_ch
);

	logic        valid_q;
	logic [31:0] value_q;
	logic [7:0]  count_q;
	logic        last_q;

	assign q_pop = q_valid && (!valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (q_pop) valid_q <= 1'b1;
		else if (out_ch.ready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_q <= q_entry.value;
			count_q <= q_entry.clip ? q_entry.rem_lo : q_entry.count;
			last_q  <= q_entry.clip;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.pixel_value  = value_q;
	assign out_ch.repeat_count = count_q;
	assign out_ch.last_pixel   = last_q;

endmodule

// ----- dv/tga_rle_pixel_decoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for tga_rle_pixel_decoder: drives Targa pixel byte streams
// and checks every (value, repeat count, last) transaction against a local predictor.
// Depends on trp_pkg, trp_if and the decoder RTL.
module tga_rle_pixel_decoder_tb;

	localparam int ITEMS       = 1200;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum logic [1:0] {PKT_HEADER, PKT_RAW, PKT_REPEAT} pkt_state_t;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} stream_byte_t;

	typedef struct {
		logic [31:0] value;
		logic [7:0]  count;
		logic        last;
	} pixel_run_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [trp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [trp_pkg::CFG_DATA_W-1:0] cfg_wdata;

	trp_in_if  in_ch();
	trp_out_if out_ch();

	tga_rle_pixel_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of the registers
	logic        rle_mode    = 1'b1;
	logic [2:0]  pixel_bytes = 3'd3;
	logic [15:0] img_w       = 16'd1;
	logic [15:0] img_h       = 16'd1;

	// predictor decode state
	pkt_state_t  pkt_state   = PKT_HEADER;
	logic [7:0]  run_left    = '0;
	logic [1:0]  gathered_n  = '0;
	logic [31:0] gather_word = '0;
	logic [31:0] pixels_owed = '0;

	stream_byte_t bytes_to_send[$];
	stream_byte_t next_byte;
	pixel_run_t   pixels_due[$];
	pixel_run_t   due;

	int idle_pct;
	int failures;
	int pixels_taken;
	int hold_left;
	bit hold_done;
	int cycles;
	int bytes_fed;
	int phase_fed;
	int phase_n;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int eff_bytes();
		if (pixel_bytes == 3'd0)
			return 1;
		if (pixel_bytes > 3'd4)
			return 4;
		return int'(pixel_bytes);
	endfunction

	function automatic void owe_pixel(logic [31:0] v, int n);
		if (n > pixels_owed)
			n = int'(pixels_owed);
		pixels_owed -= n;
		pixels_due.push_back('{v, 8'(n), pixels_owed == 0});
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic s);
		int          eff;
		logic [31:0] word;
		eff = eff_bytes();
		if (s) begin
			pkt_state   = PKT_HEADER;
			run_left    = '0;
			gathered_n  = '0;
			gather_word = '0;
			pixels_owed = 32'(img_w) * 32'(img_h);
		end
		if (pixels_owed == 0)
			return;
		if (rle_mode && pkt_state == PKT_HEADER) begin
			pkt_state   = b[7] ? PKT_REPEAT : PKT_RAW;
			run_left    = b[7] ? {1'b0, b[6:0]} : b;
			gathered_n  = '0;
			gather_word = '0;
			return;
		end
		gather_word |= 32'(b) << (8 * gathered_n);
		if (int'(gathered_n) + 1 < eff) begin
			gathered_n++;
			return;
		end
		word        = gather_word;
		gathered_n  = '0;
		gather_word = '0;
		if (!rle_mode) begin
			owe_pixel(word, 1);
		end else if (pkt_state == PKT_REPEAT) begin
			pkt_state = PKT_HEADER;
			owe_pixel(word, int'(run_left) + 1);
		end else begin
			if (run_left == 0)
				pkt_state = PKT_HEADER;
			else
				run_left--;
			owe_pixel(word, 1);
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid       <= 1'b0;
			in_ch.data_byte   <= '0;
			in_ch.image_start <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				decode_byte(in_ch.data_byte, in_ch.image_start);
			if (!in_ch.valid || in_ch.ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_byte          = bytes_to_send.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.data_byte   <= next_byte.data;
					in_ch.image_start <= next_byte.start;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				pixels_taken++;
				if (pixels_due.size() == 0) begin
					$error("unexpected transaction: pixel_value %h repeat_count %0d",
						out_ch.pixel_value, out_ch.repeat_count);
					failures++;
				end else begin
					due = pixels_due.pop_front();
					if (out_ch.pixel_value !== due.value) begin
						$error("pixel_value expected %h got %h", due.value, out_ch.pixel_value);
						failures++;
					end
					if (out_ch.repeat_count !== due.count) begin
						$error("repeat_count expected %0d got %0d", due.count,
							out_ch.repeat_count);
						failures++;
					end
					if (out_ch.last_pixel !== due.last) begin
						$error("last_pixel expected %0d got %0d", due.last, out_ch.last_pixel);
						failures++;
					end
				end
			end
			if (!hold_done && pixels_taken >= 120 && bytes_to_send.size() >= 20) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= $urandom_range(99) >= idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(logic [trp_pkg::CFG_IDX_W-1:0] idx,
		logic [trp_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			trp_pkg::REG_RLE_ENABLE: rle_mode    = data[0];
			trp_pkg::REG_BPP:        pixel_bytes = data[2:0];
			trp_pkg::REG_WIDTH:      img_w       = data;
			trp_pkg::REG_HEIGHT:     img_h       = data;
			default: ;
		endcase
	endtask

	// idle point: all bytes taken, all pixels back, and time for header-only work
	task automatic wait_drain();
		do
			@(negedge clk);
		while (bytes_to_send.size() != 0 || in_ch.valid || pixels_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	function automatic void push_byte(logic [7:0] b, logic s);
		bytes_to_send.push_back('{b, s});
	endfunction

	function automatic logic [15:0] pick_dim();
		case ($urandom_range(19))
			0:       return 16'd0;
			1:       return 16'hffff;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic random_config();
		logic [2:0] bpp_pick;
		bpp_pick = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
		write_reg(trp_pkg::REG_RLE_ENABLE, 16'($urandom));
		write_reg(trp_pkg::REG_BPP, {13'($urandom), bpp_pick});
		write_reg(trp_pkg::REG_WIDTH, pick_dim());
		write_reg(trp_pkg::REG_HEIGHT, pick_dim());
	endtask

	// one image, mostly well formed; sometimes cut short, with noise or trailing bytes
	function automatic int gen_image();
		logic [7:0]  body[$];
		logic [31:0] area;
		int          target, left, n, lits, keep, eff;
		eff    = eff_bytes();
		area   = 32'(img_w) * 32'(img_h);
		target = (area > 40) ? 40 : int'(area);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 4))
				push_byte(8'($urandom), $urandom_range(3) == 0);
		left = (target == 0) ? 3 : target;
		while (left > 0) begin
			if (!rle_mode) begin
				n    = 1;
				lits = 1;
			end else if ($urandom_range(1)) begin
				n = ($urandom_range(3) == 0) ? $urandom_range(1, 128)
					: $urandom_range(1, (left > 128) ? 128 : left);
				lits = 1;
				body.push_back(8'h80 | 8'(n - 1));
			end else begin
				n = ($urandom_range(15) == 0) ? $urandom_range(1, 128)
					: $urandom_range(1, (left > 128) ? 128 : left);
				lits = n;
				body.push_back(8'(n - 1));
			end
			repeat (lits * eff) body.push_back(8'($urandom));
			left -= n;
		end
		if ($urandom_range(7) == 0 && body.size() > 1)
			keep = $urandom_range(1, body.size() - 1);
		else
			keep = body.size();
		for (int i = 0; i < keep; i++)
			push_byte(body[i], i == 0);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
		return (target == 0) ? 0 : keep;
	endfunction

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_pct  = 17;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: byte before any image, repeat cut to a 1x1 image, trailing byte
		push_byte(8'haa, 1'b0);
		push_byte(8'hff, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'h80, 1'b0);
		wait_drain();

		// oversize bpp acts as 4; repeat, raw, then a run cut at the image end
		write_reg(trp_pkg::REG_RLE_ENABLE, 16'd1);
		write_reg(trp_pkg::REG_BPP, 16'd7);
		write_reg(trp_pkg::REG_WIDTH, 16'd5);
		write_reg(trp_pkg::REG_HEIGHT, 16'd2);
		@(negedge clk);
		push_byte(8'h81, 1'b1);
		repeat (4) push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		repeat (4) push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h5a, 1'b0);
		push_byte(8'ha5, 1'b0);
		push_byte(8'h3c, 1'b0);
		push_byte(8'hc3, 1'b0);
		wait_drain();

		// plain mode, zero bpp acts as 1
		write_reg(trp_pkg::REG_RLE_ENABLE, 16'd0);
		write_reg(trp_pkg::REG_BPP, 16'd0);
		write_reg(trp_pkg::REG_WIDTH, 16'd2);
		write_reg(trp_pkg::REG_HEIGHT, 16'd1);
		@(negedge clk);
		push_byte(8'h12, 1'b1);
		push_byte(8'hed, 1'b0);
		push_byte(8'h55, 1'b0);

		while (bytes_fed < ITEMS) begin
			wait_drain();
			idle_pct <= (phase_n == 2) ? 0 : 17;
			random_config();
			@(negedge clk);
			phase_fed = 0;
			for (int k = 0; k < 30 && phase_fed < 100; k++)
				phase_fed += gen_image();
			bytes_fed += phase_fed;
			phase_n++;
		end
		wait_drain();
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
